// File: rtl/lfps_pkg.sv
// lfps_pkg: shared widths, register map, reset values and bus structs for the
// line-follow steering controller. No dependencies.

package lfps_pkg;

   localparam int POS_W     = 8;
   localparam int ERR_W     = 9;
   localparam int DIFF_W    = 10;
   localparam int GAIN_W    = 16;
   localparam int SPD_W     = 8;
   // window sum carried between blocks, wide enough for the largest window
   localparam int SUM_MAX_W = 15;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [POS_W-1:0] STOP_CODE = 8'hFF;

   // register indexes, byte address is four times the index
   localparam logic [2:0] REG_KP         = 3'd0;
   localparam logic [2:0] REG_KD         = 3'd1;
   localparam logic [2:0] REG_KI         = 3'd2;
   localparam logic [2:0] REG_SET_POINT  = 3'd3;
   localparam logic [2:0] REG_BASE_SPEED = 3'd4;
   localparam logic [2:0] REG_MAX_SPEED  = 3'd5;

   localparam logic [POS_W-1:0] SET_POINT_RST  = 8'd35;
   localparam logic [SPD_W-1:0] BASE_SPEED_RST = 8'd100;
   localparam logic [SPD_W-1:0] MAX_SPEED_RST  = 8'd200;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] kd;
      logic signed [GAIN_W-1:0] ki;
      logic [POS_W-1:0]         set_point;
      logic [SPD_W-1:0]         base_speed;
      logic [SPD_W-1:0]         max_speed;
   } cfg_type;

   typedef struct packed {
      logic                        stop;
      logic signed [ERR_W-1:0]     err;
      logic signed [DIFF_W-1:0]    diff;
      logic signed [SUM_MAX_W-1:0] sum;
   } win_type;

endpackage

// File: rtl/lfps_csr.sv
// lfps_csr: register file behind the configuration port.
// Depends on lfps_pkg for the register map, reset values and cfg_type.

module lfps_csr
   import lfps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp         <= '0;
         cfg_ff.kd         <= '0;
         cfg_ff.ki         <= '0;
         cfg_ff.set_point  <= SET_POINT_RST;
         cfg_ff.base_speed <= BASE_SPEED_RST;
         cfg_ff.max_speed  <= MAX_SPEED_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_KP:         cfg_ff.kp         <= pwdata[GAIN_W-1:0];
            REG_KD:         cfg_ff.kd         <= pwdata[GAIN_W-1:0];
            REG_KI:         cfg_ff.ki         <= pwdata[GAIN_W-1:0];
            REG_SET_POINT:  cfg_ff.set_point  <= pwdata[POS_W-1:0];
            REG_BASE_SPEED: cfg_ff.base_speed <= pwdata[SPD_W-1:0];
            REG_MAX_SPEED:  cfg_ff.max_speed  <= pwdata[SPD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_KP:         prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_ff.kp};
         REG_KD:         prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_ff.kd};
         REG_KI:         prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_ff.ki};
         REG_SET_POINT:  prdata = {{(DATA_W-POS_W){1'b0}}, cfg_ff.set_point};
         REG_BASE_SPEED: prdata = {{(DATA_W-SPD_W){1'b0}}, cfg_ff.base_speed};
         REG_MAX_SPEED:  prdata = {{(DATA_W-SPD_W){1'b0}}, cfg_ff.max_speed};
         default:        prdata = '0;
      endcase
   end

endmodule

// File: rtl/lfps_window.sv
// lfps_window: error ring memory with running sum and previous error.
// Reads the slot on acceptance, writes it back one stage later with forwarding.
// Depends on lfps_pkg for widths and win_type.

module lfps_window
   import lfps_pkg::*;
#(
   parameter int WINDOW = 10
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [POS_W-1:0] set_point,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [POS_W-1:0] in_position,
   output logic             out_valid,
   input  logic             out_ready,
   output win_type          out_item
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = ERR_W + $clog2(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   logic signed [ERR_W-1:0] mem [WINDOW];

   logic [IDX_W-1:0]        windex_ff;
   logic [IDX_W-1:0]        windex_in;
   logic [WINDOW-1:0]       valid_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [ERR_W-1:0] prev_ff;
   logic                    s1_vld_ff;
   logic                    s1_stop_ff;
   logic signed [ERR_W-1:0] s1_err_ff;
   logic [IDX_W-1:0]        s1_slot_ff;
   logic signed [ERR_W-1:0] rdata_ff;
   logic                    fwd_hit_ff;
   logic signed [ERR_W-1:0] fwd_err_ff;

   logic                    accept;
   logic                    leave;
   logic                    wr_en;
   logic                    pos_stop;
   logic signed [ERR_W-1:0] err_now;
   logic signed [ERR_W-1:0] old_err;
   logic signed [SUM_W+1:0] sum_wide;
   logic signed [SUM_W-1:0] sum_new;
   logic signed [DIFF_W-1:0] diff;

   assign in_ready  = !s1_vld_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign leave     = s1_vld_ff && out_ready;
   assign wr_en     = leave && !s1_stop_ff;
   assign pos_stop  = (in_position == STOP_CODE);
   assign err_now   = $signed({1'b0, in_position}) - $signed({1'b0, set_point});
   assign windex_in = (windex_ff == LAST_IDX) ? '0 : windex_ff + IDX_W'(1);

   // the item ahead writes back on the edge that reads for this one
   assign old_err  = fwd_hit_ff ? fwd_err_ff :
                     (valid_ff[s1_slot_ff] ? rdata_ff : '0);
   assign sum_wide = (SUM_W+2)'(sum_ff) - (SUM_W+2)'(old_err) + (SUM_W+2)'(s1_err_ff);
   assign sum_new  = sum_wide[SUM_W-1:0];
   assign diff     = DIFF_W'(s1_err_ff) - DIFF_W'(prev_ff);

   assign out_valid     = s1_vld_ff;
   assign out_item.stop = s1_stop_ff;
   assign out_item.err  = s1_err_ff;
   assign out_item.diff = diff;
   assign out_item.sum  = SUM_MAX_W'(sum_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         windex_ff  <= '0;
         valid_ff   <= '0;
         sum_ff     <= '0;
         prev_ff    <= '0;
         s1_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_vld_ff  <= 1'b1;
            fwd_hit_ff <= wr_en && (s1_slot_ff == windex_ff);
            if (!pos_stop) begin
               windex_ff <= windex_in;
            end
         end else if (leave) begin
            s1_vld_ff <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[s1_slot_ff] <= 1'b1;
            sum_ff               <= sum_new;
            prev_ff              <= s1_err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stop_ff <= pos_stop;
         s1_err_ff  <= err_now;
         s1_slot_ff <= windex_ff;
         fwd_err_ff <= s1_err_ff;
         rdata_ff   <= mem[windex_ff];
      end
      if (wr_en) begin
         mem[s1_slot_ff] <= s1_err_ff;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      windex_ff <= LAST_IDX)
      else $error("ring index beyond window");

   a_stop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      leave && s1_stop_ff |=> $stable(sum_ff) && $stable(prev_ff))
      else $error("stop item changed controller state");

   a_writeback_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(s1_slot_ff)])
      else $error("written slot not marked valid");

endmodule

// File: rtl/lfps_drive.sv
// lfps_drive: gain multiplies, drive sum, steering and speed clamp with the
// result register. Depends on lfps_pkg for widths, cfg_type and win_type.

module lfps_drive
   import lfps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  win_type          in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [SPD_W-1:0] out_right,
   output logic [SPD_W-1:0] out_left,
   output logic             out_stop
);

   localparam int P_W   = GAIN_W + ERR_W;
   localparam int D_W   = GAIN_W + DIFF_W;
   localparam int I_W   = GAIN_W + SUM_MAX_W;
   localparam int DRV_W = I_W + 2;
   localparam int MOV_W = DRV_W + 1;

   logic                  s2_vld_ff;
   logic                  s2_stop_ff;
   logic                  s2_neg_ff;
   logic signed [P_W-1:0] p_ff;
   logic signed [D_W-1:0] d_ff;
   logic signed [I_W-1:0] i_ff;
   logic signed [P_W-1:0] p_in;
   logic signed [D_W-1:0] d_in;
   logic signed [I_W-1:0] i_in;

   logic                    s3_vld_ff;
   logic                    s3_stop_ff;
   logic                    s3_neg_ff;
   logic signed [DRV_W-1:0] drive_ff;
   logic signed [DRV_W-1:0] drive_in;

   logic                    out_vld_ff;
   logic                    out_stop_ff;
   logic [SPD_W-1:0]        right_ff;
   logic [SPD_W-1:0]        left_ff;
   logic signed [MOV_W-1:0] base_s;
   logic signed [MOV_W-1:0] moved_in;
   logic [SPD_W-1:0]        moved_spd;
   logic [SPD_W-1:0]        base_spd;

   logic s2_rdy;
   logic s3_rdy;
   logic s4_rdy;

   function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [MOV_W-1:0] s,
                                                     input logic [SPD_W-1:0] max_spd);
      logic signed [MOV_W-1:0] max_s;
      max_s = $signed({{(MOV_W-SPD_W){1'b0}}, max_spd});
      if (s > max_s) begin
         clamp_speed = max_spd;
      end else if (s < 0) begin
         clamp_speed = '0;
      end else begin
         clamp_speed = s[SPD_W-1:0];
      end
   endfunction

   assign s4_rdy   = !out_vld_ff || out_ready;
   assign s3_rdy   = !s3_vld_ff || s4_rdy;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign in_ready = s2_rdy;

   assign p_in = P_W'($signed(cfg.kp)) * P_W'($signed(in_item.err));
   assign d_in = D_W'($signed(cfg.kd)) * D_W'($signed(in_item.diff));
   assign i_in = I_W'($signed(cfg.ki)) * I_W'($signed(in_item.sum));

   assign drive_in = DRV_W'(p_ff) + DRV_W'(d_ff) + DRV_W'(i_ff);

   assign base_s    = $signed({{(MOV_W-SPD_W){1'b0}}, cfg.base_speed});
   assign moved_in  = s3_neg_ff ? base_s - MOV_W'(drive_ff) : base_s + MOV_W'(drive_ff);
   assign moved_spd = clamp_speed(moved_in, cfg.max_speed);
   assign base_spd  = clamp_speed(base_s, cfg.max_speed);

   assign out_valid = out_vld_ff;
   assign out_right = right_ff;
   assign out_left  = left_ff;
   assign out_stop  = out_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s2_rdy) begin
            s2_vld_ff <= in_valid;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_rdy) begin
            out_vld_ff <= s3_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && in_valid) begin
         s2_stop_ff <= in_item.stop;
         s2_neg_ff  <= in_item.err[ERR_W-1];
         p_ff       <= p_in;
         d_ff       <= d_in;
         i_ff       <= i_in;
      end
      if (s3_rdy && s2_vld_ff) begin
         s3_stop_ff <= s2_stop_ff;
         s3_neg_ff  <= s2_neg_ff;
         drive_ff   <= drive_in;
      end
      if (s4_rdy && s3_vld_ff) begin
         out_stop_ff <= s3_stop_ff;
         if (s3_stop_ff) begin
            right_ff <= '0;
            left_ff  <= '0;
         end else if (s3_neg_ff) begin
            right_ff <= moved_spd;
            left_ff  <= base_spd;
         end else begin
            right_ff <= base_spd;
            left_ff  <= moved_spd;
         end
      end
   end

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_stop_ff |-> right_ff == '0 && left_ff == '0)
      else $error("stop result with non-zero speed");

   a_drive_held: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff && !s4_rdy |=> s3_vld_ff && $stable(drive_ff))
      else $error("drive stage lost while stalled");

   a_products_held: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff && !s3_rdy |=> s2_vld_ff && $stable(p_ff) && $stable(i_ff))
      else $error("product stage lost while stalled");

endmodule

// File: rtl/line_follow_pid_steering.sv
// line_follow_pid_steering: PID steering for a line-following two-wheel drive.
// Input stream req_: one line-position byte per transfer; 255 means line lost.
// Output stream rsp_: right and left motor duty in tdata, stopped flag in tuser.
// Configuration by APB-style csr_ port: kp, kd, ki, set point, base and max speed.
// Gains are applied as kp*error + kd*(error change) + ki*(sum of last WINDOW errors).
// Throughput: one transfer per cycle while rsp_ is not stalled. The error ring
// sits in a one-read, one-write memory; the slot is read on acceptance and
// written back when the item leaves the ring-read stage, with a forwarding
// register for the item that follows directly. Pipeline: the transfer loads
// the ring-read stage, then gain multiplies, drive sum, and steering with
// clamp into the output register are each registered in turn.
// A stalled rsp_ side fills the four stages before req_tready drops; the
// output register holds the result until it is taken.
// Reset (synchronous, active high) restores register defaults and clears the
// ring at once through per-slot valid bits; no clearing pass is needed.
// Line-lost items give zero speeds with stopped set and leave the state alone.
// Depends on lfps_pkg, lfps_csr, lfps_window and lfps_drive.

module line_follow_pid_steering
   import lfps_pkg::*;
#(
   parameter int WINDOW = 10
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] position
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [7:0] right_speed, [15:8] left_speed
   output logic [0:0]        rsp_tuser,   // [0] stopped
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type          cfg;
   win_type          win_item;
   logic             win_valid;
   logic             win_ready;
   logic [SPD_W-1:0] right_speed;
   logic [SPD_W-1:0] left_speed;
   logic             stopped;

   lfps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lfps_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .set_point   (cfg.set_point),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_position (req_tdata[POS_W-1:0]),
      .out_valid   (win_valid),
      .out_ready   (win_ready),
      .out_item    (win_item)
   );

   lfps_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_item   (win_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_right (right_speed),
      .out_left  (left_speed),
      .out_stop  (stopped)
   );

   assign rsp_tdata = {left_speed, right_speed};
   assign rsp_tuser = stopped;

endmodule

// File: tb/line_follow_pid_steering_tb.sv
// line_follow_pid_steering_tb: self-checking bench for the line-follow steering block.
// Streams position bytes into req_, predicts the motor speeds of every transfer and
// checks them on rsp_; settings go in over csr_. Depends on lfps_pkg and the block.

module line_follow_pid_steering_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lfps_pkg::*;

   localparam int RING_DEPTH      = 10;
   localparam int SUM_W           = 14;
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int IDLE_PERCENT    = 12;
   localparam int ROUNDS          = 8;
   localparam int ROUND_ITEMS     = 200;

   // indexes past the register list, writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [SPD_W-1:0] right;
      logic [SPD_W-1:0] left;
      logic             stopped;
   } speeds_type;

   class steering_predictor;
      logic signed [GAIN_W-1:0] kp, kd, ki;
      logic [POS_W-1:0]         set_point;
      logic [SPD_W-1:0]         base_speed, max_speed;
      logic signed [ERR_W-1:0]  err_ring [RING_DEPTH];
      int unsigned              ring_slot;
      logic signed [SUM_W-1:0]  ring_sum;
      logic signed [ERR_W-1:0]  last_err;
      speeds_type               speed_queue [$];
      int                       mismatches, results, stops;

      function new();
         kp = '0;
         kd = '0;
         ki = '0;
         set_point  = SET_POINT_RST;
         base_speed = BASE_SPEED_RST;
         max_speed  = MAX_SPEED_RST;
         foreach (err_ring[i]) err_ring[i] = '0;
         ring_slot  = 0;
         ring_sum   = '0;
         last_err   = '0;
         mismatches = 0;
         results    = 0;
         stops      = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_KP:         kp = value[GAIN_W-1:0];
            REG_KD:         kd = value[GAIN_W-1:0];
            REG_KI:         ki = value[GAIN_W-1:0];
            REG_SET_POINT:  set_point = value[POS_W-1:0];
            REG_BASE_SPEED: base_speed = value[SPD_W-1:0];
            REG_MAX_SPEED:  max_speed = value[SPD_W-1:0];
            default: ;
         endcase
      endfunction

      function void check_register(logic [2:0] idx, logic [DATA_W-1:0] data);
         logic [GAIN_W-1:0] want, got;
         string             name;
         want = '0;
         got  = '0;
         name = "none";
         case (idx)
            REG_KP: begin
               name = "kp"; want = kp; got = data[GAIN_W-1:0];
            end
            REG_KD: begin
               name = "kd"; want = kd; got = data[GAIN_W-1:0];
            end
            REG_KI: begin
               name = "ki"; want = ki; got = data[GAIN_W-1:0];
            end
            REG_SET_POINT: begin
               name = "set_point"; want = 16'(set_point); got = 16'(data[POS_W-1:0]);
            end
            REG_BASE_SPEED: begin
               name = "base_speed"; want = 16'(base_speed); got = 16'(data[SPD_W-1:0]);
            end
            REG_MAX_SPEED: begin
               name = "max_speed"; want = 16'(max_speed); got = 16'(data[SPD_W-1:0]);
            end
            default: ;
         endcase
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function logic [SPD_W-1:0] limit_speed(longint s);
         if (s > longint'(max_speed)) s = longint'(max_speed);
         if (s < 0) s = 0;
         return s[SPD_W-1:0];
      endfunction

      function void note_position(logic [POS_W-1:0] pos);
         longint     err, sum_next, drive, right, left;
         speeds_type exp_speeds;
         if (pos == STOP_CODE) begin
            // line lost: motors stop, ring and last error untouched
            exp_speeds = '{right: '0, left: '0, stopped: 1'b1};
            stops++;
         end else begin
            err = longint'(pos) - longint'(set_point);
            sum_next = longint'(ring_sum) - longint'(err_ring[ring_slot]) + err;
            ring_sum = sum_next[SUM_W-1:0];
            err_ring[ring_slot] = err[ERR_W-1:0];
            ring_slot = (ring_slot + 1) % RING_DEPTH;
            drive = longint'(kp) * err
                  + longint'(kd) * (err - longint'(last_err))
                  + longint'(ki) * longint'(ring_sum);
            last_err = err[ERR_W-1:0];
            if (err >= 0) begin
               right = longint'(base_speed);
               left  = longint'(base_speed) + drive;
            end else begin
               right = longint'(base_speed) - drive;
               left  = longint'(base_speed);
            end
            exp_speeds = '{right: limit_speed(right), left: limit_speed(left),
                           stopped: 1'b0};
         end
         speed_queue.push_back(exp_speeds);
      endfunction

      function void check_speeds(logic [SPD_W-1:0] right, logic [SPD_W-1:0] left,
                                 logic stopped);
         speeds_type due;
         results++;
         if (speed_queue.size() == 0) begin
            $error("result with none outstanding: right_speed=%0d left_speed=%0d stopped=%0b",
                   right, left, stopped);
            mismatches++;
            return;
         end
         due = speed_queue.pop_front();
         if (right !== due.right) begin
            $error("right_speed: expected %0d, actual %0d", due.right, right);
            mismatches++;
         end
         if (left !== due.left) begin
            $error("left_speed: expected %0d, actual %0d", due.left, left);
            mismatches++;
         end
         if (stopped !== due.stopped) begin
            $error("stopped: expected %0b, actual %0b", due.stopped, stopped);
            mismatches++;
         end
      endfunction

      function int pending();
         return speed_queue.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // [7:0] position
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;   // [7:0] right_speed, [15:8] left_speed
   logic [0:0]        rsp_tuser;   // [0] stopped
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   steering_predictor predictor = new();

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit stall_request  = 1'b0;
   int settings_used  = 0;
   int idle_cycles    = 0;

   line_follow_pid_steering #(.WINDOW(RING_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5ns clock = ~clock;

   task automatic send_position(input logic [POS_W-1:0] pos);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pos;
      do @(posedge clock); while (!req_tready);
      predictor.note_position(pos);
   endtask

   // sender goes quiet until every outstanding result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.set_register(idx, value);
   endtask

   task automatic csr_check(input logic [2:0] idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.check_register(idx, csr_prdata);
   endtask

   task automatic csr_check_all();
      for (int i = REG_KP; i <= REG_MAX_SPEED; i++) csr_check(3'(i));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input logic signed [GAIN_W-1:0] kp,
                                 input logic signed [GAIN_W-1:0] kd,
                                 input logic signed [GAIN_W-1:0] ki,
                                 input logic [POS_W-1:0] set_point,
                                 input logic [SPD_W-1:0] base_speed,
                                 input logic [SPD_W-1:0] max_speed);
      drain();
      // upper bits carry noise, only the register width counts
      csr_write(REG_KP, {16'($urandom()), kp});
      csr_write(REG_KD, {16'($urandom()), kd});
      csr_write(REG_KI, {16'($urandom()), ki});
      csr_write(REG_SET_POINT, {24'($urandom()), set_point});
      csr_write(REG_BASE_SPEED, {24'($urandom()), base_speed});
      csr_write(REG_MAX_SPEED, {24'($urandom()), max_speed});
      csr_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
      csr_check_all();
      settings_used++;
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      int g;
      case ($urandom_range(4))
         0, 1: g = $urandom_range(32) - 16;
         2:    g = $urandom_range(2048) - 1024;
         3:    g = $urandom();
         default: g = $urandom_range(1) ? 32767 : -32768;
      endcase
      return g[GAIN_W-1:0];
   endfunction

   function automatic logic [SPD_W-1:0] pick_speed();
      if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [POS_W-1:0] pick_set_point();
      case ($urandom_range(19))
         0: return 8'd0;
         1: return 8'd254;
         2: return 8'd255;
         default: return 8'($urandom_range(254));
      endcase
   endfunction

   // mostly readings near the set point
   function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] centre);
      int r, p;
      r = $urandom_range(99);
      if (r < 5) return STOP_CODE;
      if (r < 65) begin
         p = int'(centre) + int'($urandom_range(20)) - 10;
         if (p < 0) p = 0;
         if (p > 254) p = 254;
         return p[POS_W-1:0];
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic random_settings();
      logic [SPD_W-1:0] base_speed, max_speed;
      base_speed = pick_speed();
      max_speed  = $urandom_range(3) == 0 ? pick_speed() : 8'd255;
      apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_set_point(),
                     base_speed, max_speed);
   endtask

   initial begin : receiver
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            predictor.check_speeds(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tuser[0]);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (stall_request) begin
            stall_request = 1'b0;
            hold = HOLD_OFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("line_follow_pid_steering verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero gains, so both sides sit at base speed
      csr_check_all();
      send_position(8'd35);  send_position(8'd0);   send_position(8'd254);
      send_position(STOP_CODE); send_position(8'd36);

      // window start and saturation at both ends
      apply_settings(16'sd2, -16'sd3, 16'sd1, 8'd100, 8'd128, 8'd255);
      send_position(8'd100); send_position(8'd0);   send_position(8'd254);
      send_position(STOP_CODE); send_position(8'd101); send_position(8'd99);

      apply_settings(16'sh7FFF, 16'sh8000, 16'sh8000, 8'd0, 8'd0, 8'd0);
      send_position(8'd0);   send_position(8'd254); send_position(8'd128);
      send_position(STOP_CODE);

      apply_settings(16'sh8000, 16'sh7FFF, 16'sh7FFF, 8'd254, 8'd255, 8'd255);
      send_position(8'd254); send_position(8'd0);   send_position(8'd253);
      send_position(STOP_CODE);

      // set point of 255 leaves only negative errors
      apply_settings(16'sd1, 16'sd1, 16'sd0, 8'd255, 8'd50, 8'd100);
      send_position(8'd0);   send_position(8'd254); send_position(8'd128);

      for (int round = 0; round < ROUNDS; round++) begin
         random_settings();
         sender_idles   = (round != 3);
         receiver_idles = (round != 3);
         if (round == 5) stall_request = 1'b1;
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            if (round == 6 && n == ROUND_ITEMS / 2) drain();
            send_position(pick_position(predictor.set_point));
         end
      end

      drain();
      $display("%0d speed results checked, %0d of them line-lost, over %0d register settings",
               predictor.results, predictor.stops, settings_used);
      $display("one output hold-off stretch and one sender pause included");
      if (predictor.mismatches == 0 && predictor.pending() == 0)
         $display("line_follow_pid_steering verification clean");
      else
         $display("line_follow_pid_steering verification failed");
      $finish;
   end

endmodule
